// ===== design/freu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// freu_pkg: shared types and constants
// Command codes, widths, controller states and the command/status structs.
// ----------------------------------------------------------------------------
package freu_pkg;

	localparam int unsigned DataW = 32;
	localparam int unsigned PcW = 7;
	localparam int unsigned LenW = 8;
	localparam int unsigned MaxProgram = 128;
	localparam int unsigned CntW = 6;

	typedef enum logic [3:0] {
		CMD_READ  = 4'd0,
		CMD_PRINT = 4'd1,
		CMD_MOV   = 4'd2,
		CMD_ADD   = 4'd3,
		CMD_SUB   = 4'd4,
		CMD_MUL   = 4'd5,
		CMD_DIV   = 4'd6,
		CMD_JMP   = 4'd7,
		CMD_JE    = 4'd8,
		CMD_JNE   = 4'd9,
		CMD_JG    = 4'd10,
		CMD_JGE   = 4'd11,
		CMD_JL    = 4'd12,
		CMD_JLE   = 4'd13,
		CMD_NOP   = 4'd14,
		CMD_SPARE = 4'd15
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic exec;      // latch item, evaluate and finish (non-divide)
		logic div_start; // latch item and load the divider
		logic div_step;  // one quotient bit
		logic div_done;  // write back quotient and finish
	} ctl_cmd_t;

	typedef struct packed {
		logic is_div;
		logic last_step;
	} ctl_sts_t;

endpackage

// ===== design/freu_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// freu_in_if / freu_out_if: valid/ready channels
// Input instruction words and output result words.
// ----------------------------------------------------------------------------
interface freu_in_if;
	logic valid;
	logic ready;
	logic [3:0] cmd;
	logic a_is_reg;
	logic [1:0] a_reg;
	logic signed [31:0] a_imm;
	logic b_is_reg;
	logic [1:0] b_reg;
	logic signed [31:0] b_imm;
	logic c_is_reg;
	logic [1:0] c_reg;
	logic signed [31:0] c_imm;
	logic signed [31:0] read_value;

	modport source (output valid, cmd, a_is_reg, a_reg, a_imm, b_is_reg, b_reg, b_imm,
		c_is_reg, c_reg, c_imm, read_value, input ready);
	modport sink (input valid, cmd, a_is_reg, a_reg, a_imm, b_is_reg, b_reg, b_imm,
		c_is_reg, c_reg, c_imm, read_value, output ready);
endinterface

interface freu_out_if;
	logic valid;
	logic ready;
	logic [6:0] next_pc;
	logic halted;
	logic print_valid;
	logic signed [31:0] print_value;
	logic div_fault;

	modport source (output valid, next_pc, halted, print_valid, print_value, div_fault,
		input ready);
	modport sink (input valid, next_pc, halted, print_valid, print_value, div_fault,
		output ready);
endinterface

// ===== design/freu_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// freu_ctrl: sequencing state machine
// Accepts a word, runs the divider for divides, holds the result until taken.
// ----------------------------------------------------------------------------
module freu_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  freu_pkg::ctl_sts_t  sts,
	output freu_pkg::ctl_cmd_t  cmd
);
	freu_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= freu_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			freu_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (sts.is_div) begin
						cmd.div_start = 1'b1;
						state_d = freu_pkg::ST_DIV;
					end else begin
						cmd.exec = 1'b1;
						state_d = freu_pkg::ST_OUT;
					end
				end
			end
			freu_pkg::ST_DIV: begin
				if (sts.last_step) begin
					cmd.div_done = 1'b1;
					state_d = freu_pkg::ST_OUT;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			freu_pkg::ST_OUT: begin
				out_valid = 1'b1;
				in_ready = out_ready;
				if (out_ready) begin
					if (!in_valid) begin
						state_d = freu_pkg::ST_IDLE;
					end else if (sts.is_div) begin
						cmd.div_start = 1'b1;
						state_d = freu_pkg::ST_DIV;
					end else begin
						cmd.exec = 1'b1;
					end
				end
			end
			default: state_d = freu_pkg::ST_IDLE;
		endcase
	end
endmodule

// ===== design/freu_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// freu_dp: register file, ALU, branch unit and restoring divider
// Acts only on commands from the controller.
// ----------------------------------------------------------------------------
module freu_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  freu_pkg::ctl_cmd_t cmd,
	output freu_pkg::ctl_sts_t sts,
	input  logic [7:0]         len_wr_data,
	input  logic               len_wr_en,
	freu_in_if.sink            in_ch,
	output logic [6:0]         next_pc,
	output logic               halted,
	output logic               print_valid,
	output logic signed [31:0] print_value,
	output logic               div_fault
);
	localparam int unsigned W = freu_pkg::DataW;

	logic [W-1:0] rf_q [4];
	logic [freu_pkg::PcW-1:0] pc_q;
	logic [freu_pkg::LenW-1:0] len_q;

	// Divider state.
	logic [W-1:0] rem_q, quo_q, dvs_q;
	logic neg_q, fault_q;
	logic [1:0] dst_q;
	logic [freu_pkg::CntW-1:0] cnt_q;

	// Operand fetch.
	logic [W-1:0] a, b, c, cur, wval;
	logic take, wr, lt_bc, lt_cb;
	logic [W:0] newpc; // bit W marks a negative target
	logic [freu_pkg::LenW-1:0] limit;

	assign a = in_ch.a_is_reg ? rf_q[in_ch.a_reg] : in_ch.a_imm;
	assign b = in_ch.b_is_reg ? rf_q[in_ch.b_reg] : in_ch.b_imm;
	assign c = in_ch.c_is_reg ? rf_q[in_ch.c_reg] : in_ch.c_imm;
	assign cur = rf_q[in_ch.b_reg];
	assign lt_bc = $signed(b) < $signed(c);
	assign lt_cb = $signed(c) < $signed(b);

	assign sts.is_div = (in_ch.cmd == freu_pkg::CMD_DIV);
	assign sts.last_step = (cnt_q == freu_pkg::CntW'(W));

	always_comb begin
		take = 1'b0;
		wr = 1'b0;
		wval = a;
		case (freu_pkg::cmd_t'(in_ch.cmd))
			freu_pkg::CMD_READ: begin wr = 1'b1; wval = in_ch.read_value; end
			freu_pkg::CMD_MOV:  wr = 1'b1;
			freu_pkg::CMD_ADD:  begin wr = 1'b1; wval = cur + a; end
			freu_pkg::CMD_SUB:  begin wr = 1'b1; wval = cur - a; end
			freu_pkg::CMD_MUL:  begin wr = 1'b1; wval = W'(cur * a); end
			freu_pkg::CMD_JMP:  take = 1'b1;
			freu_pkg::CMD_JE:   take = (b == c);
			freu_pkg::CMD_JNE:  take = (b != c);
			freu_pkg::CMD_JG:   take = lt_cb;
			freu_pkg::CMD_JGE:  take = !lt_bc;
			freu_pkg::CMD_JL:   take = lt_bc;
			freu_pkg::CMD_JLE:  take = !lt_cb;
			default: ;
		endcase
		newpc = take ? {a[W-1], a} : {1'b0, (W)'(pc_q) + 1'b1};
		limit = (len_q > freu_pkg::LenW'(freu_pkg::MaxProgram)) ?
			freu_pkg::LenW'(freu_pkg::MaxProgram) : len_q;
	end

	// Divider subtract step.
	logic [W:0] trial;
	logic [W-1:0] rem_sh;
	assign rem_sh = {rem_q[W-2:0], quo_q[W-1]};
	assign trial = {1'b0, rem_sh} - {1'b0, dvs_q};

	// Halt check for the pc computed at exec time or for divide (advance).
	logic halt_now;
	assign halt_now = newpc[W] || (newpc[W-1:0] >= W'(limit));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) rf_q[i] <= '0;
			pc_q <= '0;
			len_q <= '0;
			cnt_q <= '0;
			rem_q <= '0;
			quo_q <= '0;
			dvs_q <= '0;
			neg_q <= 1'b0;
			fault_q <= 1'b0;
			dst_q <= '0;
			next_pc <= '0;
			halted <= 1'b0;
			print_valid <= 1'b0;
			print_value <= '0;
			div_fault <= 1'b0;
		end else begin
			if (len_wr_en) len_q <= len_wr_data;
			if (cmd.exec || cmd.div_start) begin
				halted <= halt_now;
				next_pc <= halt_now ? '0 : newpc[freu_pkg::PcW-1:0];
				if (!halt_now) pc_q <= newpc[freu_pkg::PcW-1:0];
				print_valid <= (in_ch.cmd == freu_pkg::CMD_PRINT);
				print_value <= (in_ch.cmd == freu_pkg::CMD_PRINT) ? a : '0;
				div_fault <= cmd.div_start && (cur == '0);
			end
			if (cmd.exec && wr) rf_q[in_ch.b_reg] <= wval;
			if (cmd.div_start) begin
				dst_q <= in_ch.b_reg;
				fault_q <= (cur == '0);
				neg_q <= a[W-1] ^ cur[W-1];
				quo_q <= a[W-1] ? (0 - a) : a;
				dvs_q <= cur[W-1] ? (0 - cur) : cur;
				rem_q <= '0;
				cnt_q <= '0;
			end
			if (cmd.div_step) begin
				cnt_q <= cnt_q + 1'b1;
				if (!trial[W]) begin
					rem_q <= trial[W-1:0];
					quo_q <= {quo_q[W-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					quo_q <= {quo_q[W-2:0], 1'b0};
				end
			end
			if (cmd.div_done && !fault_q)
				rf_q[dst_q] <= neg_q ? (0 - quo_q) : quo_q;
		end
	end
endmodule

// ===== design/four_register_execute_unit_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_register_execute_unit_core: four-register instruction execute unit
// Executes one decoded instruction per word and reports the next pc.
// ----------------------------------------------------------------------------
//  Channel   Direction  Contents
//  in_ch     sink       decoded instruction word and read value
//  out_ch    source     next pc, halt, print value, divide fault
//  len_*     write      program_length register
//
// A non-divide word executes in the accepting cycle and waits in the output
// register; a following word is taken in the same cycle the result leaves.
// A divide occupies the unit through the accepting cycle, one restoring-divider
// step per quotient bit and a write-back step; its result is offered in the
// cycle after the write-back. Reset clears the registers, pc and length.
// A stalled output holds the result and blocks new input words.
// ----------------------------------------------------------------------------
module four_register_execute_unit_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       len_wr_en,
	input  logic [7:0] len_wr_data,
	freu_in_if.sink    in_ch,
	freu_out_if.source out_ch
);
	freu_pkg::ctl_cmd_t cmd;
	freu_pkg::ctl_sts_t sts;

	// The controller owns the handshakes; the datapath only executes.
	freu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	freu_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.len_wr_data (len_wr_data),
		.len_wr_en   (len_wr_en),
		.in_ch       (in_ch),
		.next_pc     (out_ch.next_pc),
		.halted      (out_ch.halted),
		.print_valid (out_ch.print_valid),
		.print_value (out_ch.print_value),
		.div_fault   (out_ch.div_fault)
	);
endmodule

// ===== tb/freu_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// freu_checker: result predictor and scoreboard
// Watches accepted instruction words, predicts each result word from its own
// copy of the registers, pc and length, and compares accepted result words.
// ----------------------------------------------------------------------------
module freu_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       len_wr_en,
	input  logic [7:0] len_wr_data,
	freu_in_if         in_mon,
	freu_out_if        out_mon,
	output int         fail_count,
	output int         pending
);

	typedef struct packed {
		logic [6:0]  next_pc;
		logic        halted;
		logic        print_valid;
		logic [31:0] print_value;
		logic        div_fault;
	} exec_result_t;

	logic [31:0] regs [4];
	logic [6:0]  pc;
	logic [7:0]  prog_len;
	exec_result_t result_q [$];

	function automatic logic [31:0] pick(input logic is_reg, input logic [1:0] r,
		input logic [31:0] imm);
		return is_reg ? regs[r] : imm;
	endfunction

	function automatic logic [31:0] sdiv(input logic [31:0] n, input logic [31:0] d);
		logic [31:0] mn, md, q;
		mn = n[31] ? -n : n;
		md = d[31] ? -d : d;
		q = mn / md;
		return (n[31] ^ d[31]) ? -q : q;
	endfunction

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
		fail_count++;
	endtask

	task automatic execute_word();
		exec_result_t r;
		logic [31:0] a, b, c, cur, npc;
		logic [1:0] dst;
		logic take;
		int unsigned lim;
		a = pick(in_mon.a_is_reg, in_mon.a_reg, in_mon.a_imm);
		b = pick(in_mon.b_is_reg, in_mon.b_reg, in_mon.b_imm);
		c = pick(in_mon.c_is_reg, in_mon.c_reg, in_mon.c_imm);
		dst = in_mon.b_reg;
		cur = regs[dst];
		npc = {25'd0, pc} + 32'd1;
		take = 1'b0;
		r = '0;
		case (freu_pkg::cmd_t'(in_mon.cmd))
			freu_pkg::CMD_READ: regs[dst] = in_mon.read_value;
			freu_pkg::CMD_PRINT: begin
				r.print_valid = 1'b1;
				r.print_value = a;
			end
			freu_pkg::CMD_MOV: regs[dst] = a;
			freu_pkg::CMD_ADD: regs[dst] = cur + a;
			freu_pkg::CMD_SUB: regs[dst] = cur - a;
			freu_pkg::CMD_MUL: regs[dst] = cur * a;
			freu_pkg::CMD_DIV: begin
				if (cur == 0) r.div_fault = 1'b1;
				else regs[dst] = sdiv(a, cur);
			end
			freu_pkg::CMD_JMP: npc = a;
			freu_pkg::CMD_JE:  take = (b == c);
			freu_pkg::CMD_JNE: take = (b != c);
			freu_pkg::CMD_JG:  take = $signed(c) < $signed(b);
			freu_pkg::CMD_JGE: take = !($signed(b) < $signed(c));
			freu_pkg::CMD_JL:  take = $signed(b) < $signed(c);
			freu_pkg::CMD_JLE: take = !($signed(c) < $signed(b));
			default: ;
		endcase
		if (take) npc = a;
		lim = (prog_len > 8'(freu_pkg::MaxProgram)) ? freu_pkg::MaxProgram : 32'(prog_len);
		if (npc[31] || npc >= lim) r.halted = 1'b1;
		else begin
			pc = npc[6:0];
			r.next_pc = pc;
		end
		result_q.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		exec_result_t e;
		if (!arst_n) begin
			regs = '{default: '0};
			pc = '0;
			prog_len = '0;
			result_q.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (len_wr_en) prog_len = len_wr_data;
			if (in_mon.valid && in_mon.ready) execute_word();
			if (out_mon.valid && out_mon.ready) begin
				if (result_q.size() == 0) begin
					report("unexpected result word", 64'd1, 64'd0);
				end else begin
					e = result_q.pop_front();
					if (out_mon.next_pc !== e.next_pc)
						report("next_pc", 64'(out_mon.next_pc), 64'(e.next_pc));
					if (out_mon.halted !== e.halted)
						report("halted", 64'(out_mon.halted), 64'(e.halted));
					if (out_mon.print_valid !== e.print_valid)
						report("print_valid", 64'(out_mon.print_valid), 64'(e.print_valid));
					if (out_mon.print_value !== e.print_value)
						report("print_value", 64'(unsigned'(out_mon.print_value)),
							64'(e.print_value));
					if (out_mon.div_fault !== e.div_fault)
						report("div_fault", 64'(out_mon.div_fault), 64'(e.div_fault));
				end
			end
			pending = result_q.size();
		end
	end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench top for the four-register execute unit
// Drives directed and random instruction words through several program
// lengths, with random idling on both channels, and reports the verdict.
// ----------------------------------------------------------------------------
module tb;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic len_wr_en = 1'b0;
	logic [7:0] len_wr_data = '0;
	int fail_count;
	int pending;
	// When set, the sender and the receiver never idle.
	bit steady = 1'b0;

	freu_in_if in_ch();
	freu_out_if out_ch();

	four_register_execute_unit_core uut (
		.clk(clk), .arst_n(arst_n), .len_wr_en(len_wr_en), .len_wr_data(len_wr_data),
		.in_ch(in_ch), .out_ch(out_ch)
	);

	freu_checker chk (
		.clk(clk), .arst_n(arst_n), .len_wr_en(len_wr_en), .len_wr_data(len_wr_data),
		.in_mon(in_ch), .out_mon(out_ch), .fail_count(fail_count), .pending(pending)
	);

	always #5 clk = ~clk;

	// The run is bounded: 1400 divides with worst-case gaps and stalls on both
	// sides stay far below this.
	initial begin
		#20ms;
		$display("*** FAILED ***");
		$finish;
	end

	// The receiver stalls in random bursts; in steady mode it is always ready.
	initial begin
		int n;
		out_ch.ready = 1'b0;
		@(posedge clk iff arst_n);
		forever begin
			if (!steady && $urandom_range(0, 3) == 0) begin
				out_ch.ready <= 1'b0;
				n = $urandom_range(1, 16);
				repeat (n) @(posedge clk);
			end else begin
				out_ch.ready <= 1'b1;
				n = $urandom_range(1, 20);
				repeat (n) @(posedge clk);
			end
		end
	end

	// Send one word: an optional idle burst first, then hold valid until the
	// word is taken. Valid is only lowered when no word follows directly.
	task automatic send_word(input logic [3:0] cmd, input logic ai, input logic [1:0] ar,
		input logic [31:0] aimm, input logic bi, input logic [1:0] br, input logic [31:0] bimm,
		input logic ci, input logic [1:0] cr, input logic [31:0] cimm, input logic [31:0] rv);
		int n;
		if (!steady && $urandom_range(0, 4) == 0) begin
			in_ch.valid <= 1'b0;
			n = $urandom_range(1, 16);
			repeat (n) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.cmd <= cmd;
		in_ch.a_is_reg <= ai;
		in_ch.a_reg <= ar;
		in_ch.a_imm <= aimm;
		in_ch.b_is_reg <= bi;
		in_ch.b_reg <= br;
		in_ch.b_imm <= bimm;
		in_ch.c_is_reg <= ci;
		in_ch.c_reg <= cr;
		in_ch.c_imm <= cimm;
		in_ch.read_value <= rv;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_value();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'hFFFF_FFFF;
			3: return $urandom_range(0, 10);
			4: return $urandom_range(0, 140);
			default: return $urandom;
		endcase
	endfunction

	// Random word: small operands and jump targets around the program limit,
	// mixed with extreme and full-range values in every field.
	task automatic send_random();
		logic [3:0] cmd;
		cmd = 4'($urandom_range(0, 15));
		send_word(cmd, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)), rand_value(),
			1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)), rand_value(),
			1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)), rand_value(), rand_value());
	endtask

	// Program length is changed only with the unit idle.
	task automatic set_length(input logic [7:0] len);
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (2) @(posedge clk);
		len_wr_en <= 1'b1;
		len_wr_data <= len;
		@(posedge clk);
		len_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		logic [7:0] lengths [6];
		int limit;
		lengths = '{8'd128, 8'd0, 8'd255, 8'd1, 8'd20, 8'd129};
		in_ch.valid = 1'b0;
		in_ch.cmd = freu_pkg::CMD_NOP;
		in_ch.a_is_reg = 1'b0;
		in_ch.a_reg = '0;
		in_ch.a_imm = '0;
		in_ch.b_is_reg = 1'b0;
		in_ch.b_reg = '0;
		in_ch.b_imm = '0;
		in_ch.c_is_reg = 1'b0;
		in_ch.c_reg = '0;
		in_ch.c_imm = '0;
		in_ch.read_value = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_length(8'd128);

		// Directed part: every command, extreme values, divide by zero and
		// divide overflow, jumps that halt, and the spare command code.
		send_word(freu_pkg::CMD_READ, 1'b0, 2'd0, 32'd0, 1'b0, 2'd0, 32'd0,
			1'b0, 2'd0, 32'd0, 32'h8000_0000);
		send_word(freu_pkg::CMD_READ, 1'b1, 2'd3, 32'hFFFF_FFFF, 1'b1, 2'd1, 32'd0,
			1'b1, 2'd3, 32'd0, 32'hFFFF_FFFF);
		send_word(freu_pkg::CMD_DIV, 1'b0, 2'd0, 32'd0, 1'b0, 2'd1, 32'd0,
			1'b0, 2'd0, 32'd0, 32'd0);
		send_word(freu_pkg::CMD_DIV, 1'b1, 2'd0, 32'd0, 1'b0, 2'd2, 32'd0,
			1'b0, 2'd0, 32'd0, 32'd0);
		send_word(freu_pkg::CMD_DIV, 1'b1, 2'd0, 32'd0, 1'b0, 2'd1, 32'd0,
			1'b0, 2'd0, 32'd0, 32'd0);
		send_word(freu_pkg::CMD_PRINT, 1'b1, 2'd1, 32'd0, 1'b0, 2'd0, 32'd0,
			1'b0, 2'd0, 32'd0, 32'd0);
		send_word(freu_pkg::CMD_PRINT, 1'b0, 2'd0, 32'h7FFF_FFFF, 1'b0, 2'd0, 32'd0,
			1'b0, 2'd0, 32'd0, 32'd0);
		send_word(freu_pkg::CMD_MOV, 1'b0, 2'd0, 32'h7FFF_FFFF, 1'b0, 2'd3, 32'd0,
			1'b0, 2'd0, 32'd0, 32'd0);
		send_word(freu_pkg::CMD_ADD, 1'b0, 2'd0, 32'd1, 1'b0, 2'd3, 32'd0,
			1'b0, 2'd0, 32'd0, 32'd0);
		send_word(freu_pkg::CMD_SUB, 1'b0, 2'd0, 32'd1, 1'b0, 2'd3, 32'd0,
			1'b0, 2'd0, 32'd0, 32'd0);
		send_word(freu_pkg::CMD_MUL, 1'b1, 2'd3, 32'd0, 1'b0, 2'd3, 32'd0,
			1'b0, 2'd0, 32'd0, 32'd0);
		send_word(freu_pkg::CMD_DIV, 1'b0, 2'd0, 32'hFFFF_FFF9, 1'b0, 2'd3, 32'd0,
			1'b0, 2'd0, 32'd0, 32'd0);
		send_word(freu_pkg::CMD_JMP, 1'b0, 2'd0, 32'd127, 1'b0, 2'd0, 32'd0,
			1'b0, 2'd0, 32'd0, 32'd0);
		send_word(freu_pkg::CMD_JMP, 1'b0, 2'd0, 32'd128, 1'b0, 2'd0, 32'd0,
			1'b0, 2'd0, 32'd0, 32'd0);
		send_word(freu_pkg::CMD_JMP, 1'b0, 2'd0, 32'hFFFF_FFFF, 1'b0, 2'd0, 32'd0,
			1'b0, 2'd0, 32'd0, 32'd0);
		send_word(freu_pkg::CMD_JE, 1'b0, 2'd0, 32'd5, 1'b0, 2'd0, 32'd3,
			1'b0, 2'd0, 32'd3, 32'd0);
		send_word(freu_pkg::CMD_JNE, 1'b0, 2'd0, 32'd9, 1'b0, 2'd0, 32'd3,
			1'b0, 2'd0, 32'd3, 32'd0);
		send_word(freu_pkg::CMD_JG, 1'b0, 2'd0, 32'd7, 1'b0, 2'd0, 32'd1,
			1'b0, 2'd0, 32'h8000_0000, 32'd0);
		send_word(freu_pkg::CMD_JGE, 1'b0, 2'd0, 32'd2, 1'b1, 2'd0, 32'd0,
			1'b1, 2'd0, 32'd0, 32'd0);
		send_word(freu_pkg::CMD_JL, 1'b0, 2'd0, 32'd4, 1'b0, 2'd0, 32'h8000_0000,
			1'b0, 2'd0, 32'h7FFF_FFFF, 32'd0);
		send_word(freu_pkg::CMD_JLE, 1'b0, 2'd0, 32'd6, 1'b0, 2'd0, 32'd9,
			1'b0, 2'd0, 32'd8, 32'd0);
		send_word(freu_pkg::CMD_NOP, 1'b1, 2'd3, 32'hFFFF_FFFF, 1'b1, 2'd3, 32'hFFFF_FFFF,
			1'b1, 2'd3, 32'hFFFF_FFFF, 32'd0);
		send_word(freu_pkg::CMD_SPARE, 1'b0, 2'd0, 32'd0, 1'b0, 2'd0, 32'd0,
			1'b0, 2'd0, 32'd0, 32'd0);

		// Random part across several lengths, the extremes among them. The
		// last stretch runs with no idling on either side.
		for (int p = 0; p < 6; p++) begin
			set_length(lengths[p]);
			if (p == 5) steady = 1'b1;
			for (int i = 0; i < 230; i++) send_random();
		end
		in_ch.valid <= 1'b0;
		@(posedge clk);

		limit = 0;
		while (pending != 0 && limit < 100000) begin
			@(posedge clk);
			limit++;
		end
		repeat (50) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
